>>> hdl/fcme_pkg.sv
// ----------------------------------------------------------------------------
// fcme_pkg
// Shared types and constants of the full checksum matrix encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcme_pkg;

   localparam int VALUE_WIDTH      = 24;
   localparam int REG_WIDTH        = 5;
   localparam int CSR_ADDR_WIDTH   = 3;
   localparam int CSR_DATA_WIDTH   = 32;
   localparam int MAX_ROWS_DEFAULT = 16;
   localparam int MAX_COLS_DEFAULT = 16;
   localparam int ELEMENT_WIDTH_DEFAULT = 16;

   localparam logic [REG_WIDTH-1:0] COUNT_RESET = 5'd16;

   localparam logic REG_ROW_COUNT = 1'b0;
   localparam logic REG_COL_COUNT = 1'b1;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_ROW   = 2'd1,
      KIND_COL   = 2'd2,
      KIND_TOTAL = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ECHO,
      ST_ROW,
      ST_COL_READ,
      ST_COL_EMIT,
      ST_TOTAL
   } state_type;

   typedef struct packed {
      logic     take;
      logic     update;
      logic     emit;
      kind_type kind;
      logic     run_last;
      logic     matrix_last;
      logic     col_step;
      logic     row_close;
      logic     col_read;
      logic     col_next;
      logic     clear;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic row_end;
      logic matrix_end;
      logic col_last;
   } ctrl_status_type;

endpackage

>>> hdl/fcme_csr.sv
// ----------------------------------------------------------------------------
// fcme_csr
// Row and column count registers with clamped effective counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcme_csr #(
   parameter int MAX_ROWS = fcme_pkg::MAX_ROWS_DEFAULT,
   parameter int MAX_COLS = fcme_pkg::MAX_COLS_DEFAULT,
   localparam int RCW = $clog2(MAX_ROWS + 1),
   localparam int CCW = $clog2(MAX_COLS + 1)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [fcme_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [fcme_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [fcme_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                  csr_pready,
   output logic [RCW-1:0]                        rows_eff,
   output logic [CCW-1:0]                        cols_eff,
   output logic                                  cfg_clear
);

   localparam int RW = fcme_pkg::REG_WIDTH;
   localparam int DW = fcme_pkg::CSR_DATA_WIDTH;

   logic [RW-1:0] row_count_ff, row_count_in;
   logic [RW-1:0] col_count_ff, col_count_in;
   logic          wr_en;
   logic          reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg_clear  = wr_en;

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      csr_prdata   = '0;
      unique case (reg_sel)
         fcme_pkg::REG_ROW_COUNT: begin
            csr_prdata = DW'(row_count_ff);
            if (wr_en) begin
               row_count_in = csr_pwdata[RW-1:0];
            end
         end
         fcme_pkg::REG_COL_COUNT: begin
            csr_prdata = DW'(col_count_ff);
            if (wr_en) begin
               col_count_in = csr_pwdata[RW-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= fcme_pkg::COUNT_RESET;
         col_count_ff <= fcme_pkg::COUNT_RESET;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
      end
   end

   // zero acts as one, too large acts as the maximum
   always_comb begin
      priority if (row_count_ff == '0) begin
         rows_eff = RCW'(1);
      end else if (int'(row_count_ff) > MAX_ROWS) begin
         rows_eff = RCW'(MAX_ROWS);
      end else begin
         rows_eff = RCW'(row_count_ff);
      end
      priority if (col_count_ff == '0) begin
         cols_eff = CCW'(1);
      end else if (int'(col_count_ff) > MAX_COLS) begin
         cols_eff = CCW'(MAX_COLS);
      end else begin
         cols_eff = CCW'(col_count_ff);
      end
   end

endmodule

>>> hdl/fcme_ctrl.sv
// ----------------------------------------------------------------------------
// fcme_ctrl
// Sequencer for element echo, row sum and checksum row emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcme_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  fcme_pkg::ctrl_status_type status,
   output fcme_pkg::ctrl_cmd_type    cmd
);

   fcme_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fcme_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.kind   = fcme_pkg::KIND_DATA;
      req_tready = 1'b0;
      unique case (state_ff)
         fcme_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               state_in = fcme_pkg::ST_ECHO;
            end
         end
         fcme_pkg::ST_ECHO: begin
            if (status.out_free) begin
               cmd.update   = 1'b1;
               cmd.emit     = 1'b1;
               cmd.kind     = fcme_pkg::KIND_DATA;
               cmd.run_last = !status.row_end;
               if (status.row_end) begin
                  state_in = fcme_pkg::ST_ROW;
               end else begin
                  cmd.col_step = 1'b1;
                  state_in     = fcme_pkg::ST_IDLE;
               end
            end
         end
         fcme_pkg::ST_ROW: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.kind      = fcme_pkg::KIND_ROW;
               cmd.run_last  = !status.matrix_end;
               cmd.row_close = 1'b1;
               state_in      = status.matrix_end ? fcme_pkg::ST_COL_READ
                                                 : fcme_pkg::ST_IDLE;
            end
         end
         fcme_pkg::ST_COL_READ: begin
            cmd.col_read = 1'b1;
            state_in     = fcme_pkg::ST_COL_EMIT;
         end
         fcme_pkg::ST_COL_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = fcme_pkg::KIND_COL;
               if (status.col_last) begin
                  state_in = fcme_pkg::ST_TOTAL;
               end else begin
                  cmd.col_next = 1'b1;
                  state_in     = fcme_pkg::ST_COL_READ;
               end
            end
         end
         fcme_pkg::ST_TOTAL: begin
            if (status.out_free) begin
               cmd.emit        = 1'b1;
               cmd.kind        = fcme_pkg::KIND_TOTAL;
               cmd.run_last    = 1'b1;
               cmd.matrix_last = 1'b1;
               cmd.clear       = 1'b1;
               state_in        = fcme_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fcme_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/fcme_dp.sv
// ----------------------------------------------------------------------------
// fcme_dp
// Indices, row/column/grand accumulators and the output word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcme_dp #(
   parameter int MAX_ROWS      = fcme_pkg::MAX_ROWS_DEFAULT,
   parameter int MAX_COLS      = fcme_pkg::MAX_COLS_DEFAULT,
   parameter int ELEMENT_WIDTH = fcme_pkg::ELEMENT_WIDTH_DEFAULT,
   localparam int RCW = $clog2(MAX_ROWS + 1),
   localparam int CCW = $clog2(MAX_COLS + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [ELEMENT_WIDTH-1:0]     element,
   input  logic [RCW-1:0]                      rows_eff,
   input  logic [CCW-1:0]                      cols_eff,
   input  logic                                cfg_clear,
   input  fcme_pkg::ctrl_cmd_type              cmd,
   output fcme_pkg::ctrl_status_type           status,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [fcme_pkg::VALUE_WIDTH-1:0]    rsp_value,
   output fcme_pkg::kind_type                  rsp_kind,
   output logic                                rsp_run_last,
   output logic                                rsp_matrix_last
);

   localparam int VW  = fcme_pkg::VALUE_WIDTH;
   localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   logic signed [ELEMENT_WIDTH-1:0] elem_ff;
   logic [VW-1:0]                   elem_ext;

   logic [RIW-1:0] row_idx_ff, row_idx_in;
   logic [CIW-1:0] col_idx_ff, col_idx_in;
   logic [CIW-1:0] col_sel_ff, col_sel_in;
   logic [VW-1:0]  row_acc_ff, row_acc_in;
   logic [VW-1:0]  grand_ff, grand_in;
   logic [MAX_COLS-1:0] col_vld_ff, col_vld_in;

   logic [VW-1:0]  col_mem [MAX_COLS];
   logic [VW-1:0]  rd_data_ff;
   logic           rd_vld_ff;
   logic [CIW-1:0] rd_addr;
   logic           rd_en;
   logic [VW-1:0]  col_sum;
   logic [VW-1:0]  mem_wdata;

   logic           out_vld_ff, out_vld_in;
   logic [VW-1:0]  out_value_ff;
   fcme_pkg::kind_type out_kind_ff;
   logic           out_run_last_ff;
   logic           out_matrix_last_ff;
   logic [VW-1:0]  emit_value;
   logic           clear_all;

   assign elem_ext  = VW'(elem_ff);
   assign col_sum   = rd_vld_ff ? rd_data_ff : '0;
   assign mem_wdata = col_sum + elem_ext;
   assign clear_all = cmd.clear | cfg_clear;
   assign rd_en     = cmd.take | cmd.col_read;
   assign rd_addr   = cmd.take ? col_idx_ff : col_sel_ff;

   assign status.out_free   = !out_vld_ff || rsp_tready;
   assign status.row_end    = (CCW'(col_idx_ff) + 1'b1) == cols_eff;
   assign status.matrix_end = status.row_end && ((RCW'(row_idx_ff) + 1'b1) == rows_eff);
   assign status.col_last   = (CCW'(col_sel_ff) + 1'b1) == cols_eff;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         elem_ff <= element;
      end
      if (cmd.update) begin
         col_mem[col_idx_ff] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= col_mem[rd_addr];
      end
   end

   always_comb begin
      row_idx_in = row_idx_ff;
      col_idx_in = col_idx_ff;
      col_sel_in = col_sel_ff;
      row_acc_in = row_acc_ff;
      grand_in   = grand_ff;
      col_vld_in = col_vld_ff;
      if (cmd.update) begin
         row_acc_in             = row_acc_ff + elem_ext;
         grand_in               = grand_ff + elem_ext;
         col_vld_in[col_idx_ff] = 1'b1;
      end
      if (cmd.col_step) begin
         col_idx_in = col_idx_ff + 1'b1;
      end
      if (cmd.row_close) begin
         row_acc_in = '0;
         col_idx_in = '0;
         if (!status.matrix_end) begin
            row_idx_in = row_idx_ff + 1'b1;
         end
      end
      if (cmd.col_next) begin
         col_sel_in = col_sel_ff + 1'b1;
      end
      if (clear_all) begin
         row_idx_in = '0;
         col_idx_in = '0;
         col_sel_in = '0;
         row_acc_in = '0;
         grand_in   = '0;
         col_vld_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_idx_ff <= '0;
         col_idx_ff <= '0;
         col_sel_ff <= '0;
         row_acc_ff <= '0;
         grand_ff   <= '0;
         col_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         row_idx_ff <= row_idx_in;
         col_idx_ff <= col_idx_in;
         col_sel_ff <= col_sel_in;
         row_acc_ff <= row_acc_in;
         grand_ff   <= grand_in;
         col_vld_ff <= col_vld_in;
         if (rd_en) begin
            rd_vld_ff <= col_vld_ff[rd_addr];
         end
      end
   end

   // output word register
   always_comb begin
      unique case (cmd.kind)
         fcme_pkg::KIND_DATA:  emit_value = elem_ext;
         fcme_pkg::KIND_ROW:   emit_value = row_acc_ff;
         fcme_pkg::KIND_COL:   emit_value = col_sum;
         fcme_pkg::KIND_TOTAL: emit_value = grand_ff;
         default:              emit_value = elem_ext;
      endcase
      if (cmd.emit) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_value_ff       <= emit_value;
         out_kind_ff        <= cmd.kind;
         out_run_last_ff    <= cmd.run_last;
         out_matrix_last_ff <= cmd.matrix_last;
      end
   end

   assign rsp_tvalid      = out_vld_ff;
   assign rsp_value       = out_value_ff;
   assign rsp_kind        = out_kind_ff;
   assign rsp_run_last    = out_run_last_ff;
   assign rsp_matrix_last = out_matrix_last_ff;

endmodule

>>> hdl/full_checksum_matrix_encoder_unit.sv
// ----------------------------------------------------------------------------
// full_checksum_matrix_encoder_unit
// Streams a matrix in row-major order and returns its full checksum matrix.
//
// req: one element per word (tdata), row-major order.
// rsp: every element is echoed (tuser kind data); after the last element of
// a row the row sum follows (kind row); after the last row come one column
// sum per column (kind column) and the grand total (kind total, tuser bit 2
// set). tlast marks the last word caused by one element.
// csr: row_count at 0x0, col_count at 0x4; writing either one restarts the
// matrix. Write only while the block is idle.
// An accepted element is held in the element register; its echo is loaded
// into the output register once the output word is free. The sequencer takes
// no new element until its echo, and at a row end the row sum, has been
// emitted; each column sum is read from the column sum memory (a registered read), then emitted.
// Reset clears all sums and sets both counts to 16. A stalled receiver
// holds the output word; one element is still accepted behind it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module full_checksum_matrix_encoder_unit #(
   parameter int MAX_ROWS      = fcme_pkg::MAX_ROWS_DEFAULT,
   parameter int MAX_COLS      = fcme_pkg::MAX_COLS_DEFAULT,
   parameter int ELEMENT_WIDTH = fcme_pkg::ELEMENT_WIDTH_DEFAULT,
   localparam int REQ_DATA_WIDTH = ((ELEMENT_WIDTH + 7) / 8) * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [REQ_DATA_WIDTH-1:0]            req_tdata,   // element_value
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [fcme_pkg::VALUE_WIDTH-1:0]     rsp_tdata,   // out_value
   output logic [2:0]                           rsp_tuser,   // out_kind, matrix_last
   output logic                                 rsp_tlast,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [fcme_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [fcme_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [fcme_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready
);

   localparam int RCW = $clog2(MAX_ROWS + 1);
   localparam int CCW = $clog2(MAX_COLS + 1);

   logic [RCW-1:0]            rows_eff;
   logic [CCW-1:0]            cols_eff;
   logic                      cfg_clear;
   fcme_pkg::ctrl_cmd_type    cmd;
   fcme_pkg::ctrl_status_type status;
   fcme_pkg::kind_type        rsp_kind;
   logic                      rsp_matrix_last;

   fcme_csr #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .rows_eff    (rows_eff),
      .cols_eff    (cols_eff),
      .cfg_clear   (cfg_clear)
   );

   fcme_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fcme_dp #(
      .MAX_ROWS      (MAX_ROWS),
      .MAX_COLS      (MAX_COLS),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .element         (req_tdata[ELEMENT_WIDTH-1:0]),
      .rows_eff        (rows_eff),
      .cols_eff        (cols_eff),
      .cfg_clear       (cfg_clear),
      .cmd             (cmd),
      .status          (status),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_value       (rsp_tdata),
      .rsp_kind        (rsp_kind),
      .rsp_run_last    (rsp_tlast),
      .rsp_matrix_last (rsp_matrix_last)
   );

   assign rsp_tuser = {rsp_matrix_last, rsp_kind};

`ifndef SYNTHESIS
   a_take_on_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> cmd.take)
      else $error("accepted word not captured");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      cmd.take |=> !req_tready)
      else $error("ready while an element is in flight");

   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("output word overwritten");

   a_matrix_last_total: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tlast && (rsp_tuser[1:0] == fcme_pkg::KIND_TOTAL))
      else $error("matrix end flag on a word other than the grand total");
`endif

endmodule

>>> tb/full_checksum_matrix_encoder_unit_tb.sv
// ----------------------------------------------------------------------------
// full_checksum_matrix_encoder_unit_tb
// Streams matrices through the encoder and checks every returned word against
// a behavioral prediction of the full checksum matrix: echoed elements, row
// sums, column sums and the grand total, with tlast and the matrix-end flag.
// Row and column counts are rewritten between matrices and in the middle of
// one. This includes zero, too large and the extremes. Both stream sides idle
// at random in several mixes, and a watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module full_checksum_matrix_encoder_unit_tb;
   import fcme_pkg::*;

   localparam int ELEM_W         = ELEMENT_WIDTH_DEFAULT;
   localparam int DRAIN_CYCLES   = 10;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int WORDS_PER_MIX  = 10;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      kind_type               kind;
      logic                   run_last;
      logic                   matrix_last;
   } checksum_word_type;

   class checksum_scoreboard;
      logic [REG_WIDTH-1:0] row_count_reg;
      logic [REG_WIDTH-1:0] col_count_reg;
      int unsigned          row_pos;
      int unsigned          col_pos;
      int                   row_sum;
      int                   grand_sum;
      int                   col_sums[MAX_COLS_DEFAULT];
      checksum_word_type    pending_words[$];
      int                   mismatches;
      int                   words_checked;
      int                   elements_seen;
      int                   matrices_closed;

      function new();
         row_count_reg = COUNT_RESET;
         col_count_reg = COUNT_RESET;
         clear_sums();
      endfunction

      function void clear_sums();
         row_pos   = 0;
         col_pos   = 0;
         row_sum   = 0;
         grand_sum = 0;
         foreach (col_sums[c]) col_sums[c] = 0;
      endfunction

      static function int unsigned clamp_count(logic [REG_WIDTH-1:0] count,
                                               int unsigned limit);
         if (count == 0) return 1;
         if (count > limit) return limit;
         return count;
      endfunction

      function int unsigned active_rows();
         return clamp_count(row_count_reg, MAX_ROWS_DEFAULT);
      endfunction

      function int unsigned active_cols();
         return clamp_count(col_count_reg, MAX_COLS_DEFAULT);
      endfunction

      function void set_count(logic reg_sel, logic [REG_WIDTH-1:0] count);
         if (reg_sel == REG_ROW_COUNT) row_count_reg = count;
         else col_count_reg = count;
         clear_sums();
      endfunction

      function void push_word(int value, kind_type kind, logic run_last,
                              logic matrix_last);
         checksum_word_type w;
         w.value       = value[VALUE_WIDTH-1:0];
         w.kind        = kind;
         w.run_last    = run_last;
         w.matrix_last = matrix_last;
         pending_words.push_back(w);
      endfunction

      function void note_element(logic [ELEM_W-1:0] raw);
         int unsigned rows;
         int unsigned cols;
         int          v;
         logic        row_end;
         logic        matrix_end;
         rows = active_rows();
         cols = active_cols();
         v    = int'($signed(raw));
         if (col_pos >= cols) col_pos = cols - 1;
         if (row_pos >= rows) row_pos = rows - 1;
         row_end    = (col_pos + 1 == cols);
         matrix_end = row_end && (row_pos + 1 == rows);
         row_sum            += v;
         col_sums[col_pos]  += v;
         grand_sum          += v;
         elements_seen++;
         push_word(v, KIND_DATA, !row_end, 1'b0);
         if (!row_end) begin
            col_pos++;
            return;
         end
         push_word(row_sum, KIND_ROW, !matrix_end, 1'b0);
         row_sum = 0;
         col_pos = 0;
         if (!matrix_end) begin
            row_pos++;
            return;
         end
         for (int c = 0; c < cols; c++) push_word(col_sums[c], KIND_COL, 1'b0, 1'b0);
         push_word(grand_sum, KIND_TOTAL, 1'b1, 1'b1);
         matrices_closed++;
         clear_sums();
      endfunction

      function void record_mismatch(string what, logic [31:0] expected,
                                    logic [31:0] actual);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %0d at %0t ns: %s expected %0h got %0h",
                     mismatches, $time, what, expected, actual);
      endfunction

      function void compare_field(string what, logic [31:0] expected,
                                  logic [31:0] actual);
         if (expected !== actual) record_mismatch(what, expected, actual);
      endfunction

      function void check_word(logic [VALUE_WIDTH-1:0] value, logic [2:0] user,
                               logic last);
         checksum_word_type w;
         words_checked++;
         if (pending_words.size() == 0) begin
            record_mismatch("unexpected word", '0, value);
            return;
         end
         w = pending_words.pop_front();
         compare_field("value", w.value, value);
         compare_field("kind", w.kind, user[1:0]);
         compare_field("tlast", w.run_last, last);
         compare_field("matrix end", w.matrix_last, user[2]);
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [ELEM_W-1:0]          req_tdata;    // element_value
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [VALUE_WIDTH-1:0]     rsp_tdata;    // out_value
   logic [2:0]                 rsp_tuser;    // out_kind, matrix_last
   logic                       rsp_tlast;
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0]  csr_paddr;
   logic [CSR_DATA_WIDTH-1:0]  csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0]  csr_prdata;
   logic                       csr_pready;

   checksum_scoreboard sb = new();
   int send_idle_pct;
   int recv_stall_pct;
   int quiet_cycles;
   int send_mix[4] = '{0, 46, 0, 29};
   int recv_mix[4] = '{0, 0, 46, 29};

   full_checksum_matrix_encoder_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_element(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // all tasks start and end on a falling edge
   task automatic send_element(input logic [ELEM_W-1:0] value);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending_words.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // write a count, then read it back
   task automatic write_count(input logic reg_sel, input logic [REG_WIDTH-1:0] count);
      logic [CSR_DATA_WIDTH-1:0] wdata;
      wdata = $urandom_range(1) ? CSR_DATA_WIDTH'($urandom) : '0;
      wdata[REG_WIDTH-1:0] = count;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.set_count(reg_sel, count);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.compare_field("csr readback", count, csr_prdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [ELEM_W-1:0] pick_element();
      int unsigned sel;
      sel = $urandom_range(7);
      case (sel)
         0: return {1'b1, {(ELEM_W-1){1'b0}}};
         1: return {1'b0, {(ELEM_W-1){1'b1}}};
         2: return '0;
         3: return '1;
         default: return ELEM_W'($urandom);
      endcase
   endfunction

   function automatic logic [REG_WIDTH-1:0] pick_count(input bit allow_big);
      int unsigned sel;
      sel = $urandom_range(9);
      if (sel == 0) return '0;
      if (sel == 1 && allow_big) return REG_WIDTH'($urandom_range(31, 16));
      return REG_WIDTH'($urandom_range(1, 4));
   endfunction

   initial begin
      int total;
      int n;
      int sent;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      rsp_tready     = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      quiet_cycles   = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero counts act as a 1 x 1 matrix
      write_count(REG_ROW_COUNT, 5'd0);
      write_count(REG_COL_COUNT, 5'd0);
      send_element(16'h7fff);
      send_element(16'h8000);
      wait_drained();
      write_count(REG_ROW_COUNT, 5'd2);
      write_count(REG_COL_COUNT, 5'd2);
      send_element(16'h7fff);
      send_element(16'h8000);
      send_element(16'h0000);
      send_element(16'hffff);
      // abandon a matrix after one element
      send_element(16'h0001);
      wait_drained();
      write_count(REG_COL_COUNT, 5'd3);
      write_count(REG_ROW_COUNT, 5'd1);
      repeat (3) send_element(16'h7fff);
      wait_drained();
      // oversized row count acts as the maximum
      write_count(REG_ROW_COUNT, 5'd31);
      write_count(REG_COL_COUNT, 5'd1);
      repeat (16) send_element(16'h8000);

      for (int mix = 0; mix < 4; mix++) begin
         send_idle_pct  = send_mix[mix];
         recv_stall_pct = recv_mix[mix];
         sent = 0;
         while (sent < WORDS_PER_MIX) begin
            wait_drained();
            write_count(REG_COL_COUNT, pick_count(1'b1));
            write_count(REG_ROW_COUNT, pick_count(sb.active_cols() <= 2));
            total = sb.active_rows() * sb.active_cols();
            repeat ($urandom_range(1, 2)) begin
               n = ($urandom_range(5) == 0) ? $urandom_range(total - 1) : total;
               repeat (n) send_element(pick_element());
               sent += n;
            end
         end
      end

      // full-width rows of the most negative element
      send_idle_pct  = 0;
      recv_stall_pct = 46;
      wait_drained();
      write_count(REG_ROW_COUNT, 5'd4);
      write_count(REG_COL_COUNT, 5'd16);
      repeat (4 * MAX_COLS_DEFAULT) send_element(16'h8000);

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("covered %0d elements, %0d closed matrices, %0d result words checked",
               sb.elements_seen, sb.matrices_closed, sb.words_checked);
      $display("sizes up to 16 rows or 16 columns, zero and oversized counts, idle mixes");
      if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/fcme_pkg.sv
hdl/fcme_csr.sv
hdl/fcme_ctrl.sv
hdl/fcme_dp.sv
hdl/full_checksum_matrix_encoder_unit.sv
tb/full_checksum_matrix_encoder_unit_tb.sv
